/* rtl/core/rcht_pkg.sv */
// Shared types, constants and the logistic lookup table of the range compliance tracker.
package rcht_pkg;

  localparam int unsigned ONE_Q15 = 32768;
  localparam int unsigned HALF_Q15 = 16384;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825043;
  localparam int unsigned FDIV_STEPS = 15;

  typedef enum logic [1:0] {
    REG_GOOD_RATE  = 2'd0,
    REG_BAD_RATE   = 2'd1,
    REG_AUTH_THR   = 2'd2,
    REG_AUTH_SHARP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic signed [31:0] sample_value;
    logic               last_field;
  } in_word_t;

  typedef struct packed {
    logic [15:0] compliance;
    logic [15:0] health_level;
    logic [15:0] authority;
    logic        overflow;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic fdiv_step;
    logic acc;
    logic mean_init;
    logic mean_step;
    logic h_mul;
    logic h_upd;
    logic a_mul;
    logic a_lut;
    logic publish;
  } rcht_cmd_t;

  typedef struct packed {
    logic fdiv_done;
    logic mean_done;
    logic last;
  } rcht_stat_t;

  typedef logic [15:0] logit_tab_t [256];

  // Rounded Q0.32 product.
  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    t = a * b + 64'h0000_0000_8000_0000;
    return t >> 32;
  endfunction

  // Logistic table, entry i at x = (2i-255)/32; quotient by shift-subtract.
  function automatic logit_tab_t build_logit();
    logit_tab_t  tab;
    logic [63:0] q2;
    logic [63:0] p;
    logic [63:0] den;
    logic [48:0] num;
    logic [33:0] r;
    logic [48:0] q;
    logic [16:0] val;
    q2 = mul_q32(EXP_STEP_Q32, EXP_STEP_Q32);
    p  = EXP_STEP_Q32;
    for (int k = 0; k < 128; k++) begin
      den = 64'h1_0000_0000 + p;
      num = {1'b1, 48'd0} + 49'(den >> 1);
      r   = '0;
      q   = '0;
      for (int i = 48; i >= 0; i--) begin
        r = {r[32:0], num[i]};
        if (64'(r) >= den) begin
          r    = 34'(64'(r) - den);
          q[i] = 1'b1;
        end
      end
      val            = q[16:0];
      tab[128 + k]   = val[15:0];
      tab[127 - k]   = 16'(17'h10000 - val);
      p              = mul_q32(p, q2);
    end
    return tab;
  endfunction

  localparam logit_tab_t LOGIT_TABLE = build_logit();

endpackage

/* rtl/core/rcht_ctrl.sv */
// Sequencer of the range compliance tracker: field divide, accumulate, run close-out.
module rcht_ctrl import rcht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rcht_stat_t stat,
  output rcht_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ACC, S_MINIT, S_MEAN, S_HMUL, S_HUPD, S_AMUL, S_ALUT, S_OUT
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.fdiv_step = (state == S_DIV);
    cmd.acc       = (state == S_ACC);
    cmd.mean_init = (state == S_MINIT);
    cmd.mean_step = (state == S_MEAN);
    cmd.h_mul     = (state == S_HMUL);
    cmd.h_upd     = (state == S_HUPD);
    cmd.a_mul     = (state == S_AMUL);
    cmd.a_lut     = (state == S_ALUT);
    cmd.publish   = (state == S_OUT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:  if (in_valid) state <= S_DIV;
        S_DIV:   if (stat.fdiv_done) state <= S_ACC;
        S_ACC:   state <= stat.last ? S_MINIT : S_IDLE;
        S_MINIT: state <= S_MEAN;
        S_MEAN:  if (stat.mean_done) state <= S_HMUL;
        S_HMUL:  state <= S_HUPD;
        S_HUPD:  state <= S_AMUL;
        S_AMUL:  state <= S_ALUT;
        S_ALUT:  state <= S_OUT;
        S_OUT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/rcht_dp.sv */
// Datapath of the range compliance tracker: score divider, run totals, health and authority.
module rcht_dp import rcht_pkg::*; #(
  parameter int MAX_FIELDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  in_word_t    in_data,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  rcht_cmd_t   cmd,
  output rcht_stat_t  stat,
  output out_word_t   out_data
);

  localparam int CNT_W  = $clog2(MAX_FIELDS + 1);
  localparam int SUM_W  = 16 + $clog2(MAX_FIELDS);
  localparam int MSTP_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIELDS);
  localparam logic [33:0] ARG_LIM = 34'd67108864;

  logic [15:0] good_rate, bad_rate, auth_thr, auth_sharp;

  always_ff @(posedge clk) begin
    if (rst) begin
      good_rate  <= 16'd3277;
      bad_rate   <= 16'd16384;
      auth_thr   <= 16'd16384;
      auth_sharp <= 16'd2560;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GOOD_RATE:  good_rate  <= cfg_data;
        REG_BAD_RATE:   bad_rate   <= cfg_data;
        REG_AUTH_THR:   auth_thr   <= cfg_data;
        REG_AUTH_SHARP: auth_sharp <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Field front end: range, excess and the cases that need no divide.
  logic signed [32:0] lo, hi, v, rng, ex;
  logic               fix_c;
  logic [15:0]        fval_c;

  always_comb begin
    lo = 33'(in_data.lower_limit);
    hi = 33'(in_data.upper_limit);
    v  = 33'(in_data.sample_value);
    rng = hi - lo;
    if (v < lo)      ex = lo - v;
    else if (v > hi) ex = v - hi;
    else             ex = '0;
    fix_c  = 1'b1;
    fval_c = 16'd0;
    if (rng < 0) begin
      fval_c = 16'd0;
    end else if (rng == 0 || ex == 0) begin
      fval_c = (ex == 0) ? 16'(ONE_Q15) : 16'd0;
    end else if (ex >= rng) begin
      fval_c = 16'd0;
    end else begin
      fix_c = 1'b0;
    end
  end

  logic        fix, last;
  logic [15:0] fval;
  logic [31:0] frem, fdiv;
  logic [14:0] fq;
  logic [3:0]  fstep;
  logic [32:0] frem2;

  assign frem2 = {frem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fix   <= fix_c;
      fval  <= fval_c;
      last  <= in_data.last_field;
      frem  <= 32'(rng - ex);
      fdiv  <= rng[31:0];
      fq    <= '0;
      fstep <= '0;
    end else if (cmd.fdiv_step) begin
      fstep <= fstep + 4'd1;
      if (frem2 >= {1'b0, fdiv}) begin
        frem <= 32'(frem2 - {1'b0, fdiv});
        fq   <= {fq[13:0], 1'b1};
      end else begin
        frem <= frem2[31:0];
        fq   <= {fq[13:0], 1'b0};
      end
    end
  end

  logic [15:0] score;
  assign score = fix ? fval : {1'b0, fq};

  // Run totals.
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic             ovf;

  always_ff @(posedge clk) begin
    if (rst || cmd.publish) begin
      sum <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.acc) begin
      if (cnt < MAX_CNT) begin
        sum <= sum + SUM_W'(score);
        cnt <= cnt + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Mean: one quotient bit per cycle.
  logic [SUM_W-1:0]  msh, mq;
  logic [CNT_W:0]    mrem, mtry;
  logic [MSTP_W-1:0] mstep;

  assign mtry = {mrem[CNT_W-1:0], msh[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.mean_init) begin
      msh   <= sum;
      mq    <= '0;
      mrem  <= '0;
      mstep <= '0;
    end else if (cmd.mean_step) begin
      mstep <= mstep + 1'b1;
      msh   <= {msh[SUM_W-2:0], 1'b0};
      if (cnt != '0 && mtry >= {1'b0, cnt}) begin
        mrem <= mtry - {1'b0, cnt};
        mq   <= {mq[SUM_W-2:0], 1'b1};
      end else begin
        mrem <= mtry;
        mq   <= {mq[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Health update and authority.
  logic [15:0]        comp, health, rate_c, auth;
  logic signed [16:0] hdiff, adiff;
  logic signed [33:0] prod, arg;
  logic [33:0]        mag;
  logic [18:0]        stepv;
  logic signed [19:0] nx;
  logic signed [33:0] argc;
  logic [33:0]        aoff;
  logic [8:0]         idx;

  always_comb begin
    rate_c = (mq[15:0] > 16'(HALF_Q15)) ? good_rate : bad_rate;
    if (rate_c > 16'(ONE_Q15)) rate_c = 16'(ONE_Q15);
    hdiff = $signed({1'b0, mq[15:0]}) - $signed({1'b0, health});
    adiff = $signed({1'b0, health}) - $signed({1'b0, auth_thr});
    mag   = prod[33] ? 34'(-prod) : 34'(prod);
    stepv = 19'((mag + 34'd16384) >> 15);
    nx    = prod[33] ? 20'($signed({4'd0, health})) - $signed({1'b0, stepv})
                     : 20'($signed({4'd0, health})) + $signed({1'b0, stepv});
    if (arg > $signed(ARG_LIM))       argc = $signed(ARG_LIM);
    else if (arg < -$signed(ARG_LIM)) argc = -$signed(ARG_LIM);
    else                              argc = arg;
    aoff = 34'(argc + $signed(ARG_LIM));
    idx  = aoff[27:19];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      health <= 16'(ONE_Q15);
    end else if (cmd.h_upd) begin
      if (nx < 0)                          health <= 16'd0;
      else if (nx > 20'sd32768)            health <= 16'(ONE_Q15);
      else                                 health <= nx[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.h_mul) begin
      comp <= mq[15:0];
      prod <= $signed({1'b0, rate_c}) * hdiff;
    end
    if (cmd.a_mul) arg <= $signed({1'b0, auth_sharp}) * adiff;
    if (cmd.a_lut) auth <= idx[8] ? LOGIT_TABLE[255] : LOGIT_TABLE[idx[7:0]];
    if (cmd.publish) begin
      out_data.compliance   <= comp;
      out_data.health_level <= health;
      out_data.authority    <= auth;
      out_data.overflow     <= ovf;
    end
  end

  assign stat.fdiv_done = (fstep == 4'(FDIV_STEPS - 1));
  assign stat.mean_done = (mstep == MSTP_W'(SUM_W - 1));
  assign stat.last      = last;

endmodule

/* rtl/core/range_compliance_health_tracker.sv */
// Top level of the range compliance health tracker.
// Each input word is one monitored field (lower limit, upper limit, sample,
// all signed Q16.16). The field score max(0, 1 - excess/range) in Q1.15 comes
// from a restoring divider that yields one quotient bit per cycle over 15 divide
// steps; each field is loaded, divided and then added into the run total.
// A field flagged last_field then closes the run: the mean over the counted
// fields comes from a second one-bit-per-cycle divider (16 + log2(MAX_FIELDS)
// steps, 22 at the default), followed by the health multiply and update, the
// authority multiply and the logistic table read before the result word is
// offered. Fields past MAX_FIELDS are not counted and set the overflow flag.
// Health starts at 1.0 after reset. A new field is taken whenever the sequencer
// is idle, even if the previous result word is still waiting on out_ready; a
// finished run only holds while that word is unread. Configuration writes are
// always taken (cfg_ready stays high) and are meant to be issued while the
// block is idle.
module range_compliance_health_tracker import rcht_pkg::*; #(
  parameter int MAX_FIELDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rcht_cmd_t  cmd;
  rcht_stat_t stat;

  // Register writes go straight into the config registers, so never stall the config channel.
  assign cfg_ready = 1'b1;

  rcht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rcht_dp #(.MAX_FIELDS(MAX_FIELDS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* test/tb_range_compliance_health_tracker.sv */
// Self-checking testbench for the range compliance health tracker.
module tb_range_compliance_health_tracker import rcht_pkg::*; ();

  localparam int NUM_FIELDS = 64;
  localparam int RANDOM_ITEMS = 1860;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  range_compliance_health_tracker #(.MAX_FIELDS(NUM_FIELDS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: registers, running totals and the logistic table.
  logic [15:0] rate_good, rate_bad, auth_thr, auth_sharp;
  logic [15:0] health_q;
  int unsigned run_sum, run_count;
  bit run_over;
  logic [15:0] logistic [256];

  out_word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int fields_sent = 0;
  int overflow_runs = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch on word %0d: %s got %0d want %0d", words_seen, what, got, want);
    errors++;
  endtask

  // Build the logistic lookup from exp(-1/32) powers in rounded Q0.32.
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  task automatic fill_logistic();
    logic [63:0] sq, pw, den, val;
    sq = qmul(EXP_STEP_Q32, EXP_STEP_Q32);
    pw = EXP_STEP_Q32;
    for (int k = 0; k < 128; k++) begin
      den = 64'h1_0000_0000 + pw;
      val = ((64'd1 << 48) + den / 2) / den;
      logistic[128 + k] = val[15:0];
      logistic[127 - k] = 16'(64'd65536 - val);
      pw = qmul(pw, sq);
    end
  endtask

  function automatic int unsigned score_of(in_word_t w);
    longint lo, hi, v, span, over;
    lo = w.lower_limit;
    hi = w.upper_limit;
    v = w.sample_value;
    span = hi - lo;
    over = 0;
    if (span < 0) return 0;
    if (v < lo) over = lo - v;
    else if (v > hi) over = v - hi;
    if (span == 0) return (over == 0) ? ONE_Q15 : 0;
    if (over >= span) return 0;
    return int'(((span - over) * 32768) / span);
  endfunction

  // Fold one field into the run; on the last field queue the expected word.
  task automatic predict_field(input in_word_t w);
    int unsigned s, comp, rate;
    longint prod, mag, stp, nx, arg, idx;
    out_word_t e;
    s = score_of(w);
    if (run_count < NUM_FIELDS) begin
      run_sum += s;
      run_count++;
    end else begin
      run_over = 1'b1;
    end
    if (!w.last_field) return;
    comp = run_count ? run_sum / run_count : 0;
    rate = (comp > HALF_Q15) ? rate_good : rate_bad;
    if (rate > ONE_Q15) rate = ONE_Q15;
    prod = longint'(rate) * (longint'(comp) - longint'(health_q));
    mag = prod < 0 ? -prod : prod;
    stp = (mag + 16384) >>> 15;
    if (prod < 0) stp = -stp;
    nx = longint'(health_q) + stp;
    if (nx < 0) nx = 0;
    if (nx > ONE_Q15) nx = ONE_Q15;
    health_q = 16'(nx);
    arg = longint'(auth_sharp) * (longint'(health_q) - longint'(auth_thr));
    if (arg > 67108864) arg = 67108864;
    if (arg < -67108864) arg = -67108864;
    idx = (arg + 67108864) >>> 19;
    if (idx > 255) idx = 255;
    e.compliance = 16'(comp);
    e.health_level = health_q;
    e.authority = logistic[idx];
    e.overflow = run_over;
    if (run_over) overflow_runs++;
    expected_words.push_back(e);
    run_sum = 0;
    run_count = 0;
    run_over = 1'b0;
  endtask

  task automatic wait_idle(input int n);
    repeat (n) @(negedge clk);
  endtask

  // Drop valid only for a gap; with no gap the next word follows on a held valid.
  task automatic send_field(input in_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      wait_idle(gap);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_field(w);
    fields_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GOOD_RATE: begin rate_good = val; end
      REG_BAD_RATE: begin rate_bad = val; end
      REG_AUTH_THR: begin auth_thr = val; end
      default: begin auth_sharp = val; end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop the input valid, hold until every expected word is back, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    wait_idle(DRAIN_CYCLES);
  endtask

  function automatic in_word_t mk(logic [31:0] lo, logic [31:0] hi, logic [31:0] v, bit last);
    in_word_t w;
    w.lower_limit = lo;
    w.upper_limit = hi;
    w.sample_value = v;
    w.last_field = last;
    return w;
  endfunction

  // Random field: mostly sane limits with nearby samples, some raw noise.
  function automatic in_word_t rand_field(bit last);
    logic [31:0] lo, hi, v;
    int unsigned span;
    if ($urandom_range(0, 9) == 0) return mk($urandom, $urandom, $urandom, last);
    lo = $urandom;
    span = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : $urandom >> $urandom_range(0, 31);
    hi = lo + span;
    case ($urandom_range(0, 3))
      0: v = lo + $urandom_range(0, span);
      1: v = lo - ($urandom >> $urandom_range(1, 31));
      2: v = hi + ($urandom >> $urandom_range(1, 31));
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 19) == 0) return mk(hi, lo, v, last);
    return mk(lo, hi, v, last);
  endfunction

  // Output side: random stalls per word, check fields against the oldest expectation.
  initial begin
    out_word_t e;
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word, compliance", out_data.compliance, 16'd0);
        end else begin
          e = expected_words.pop_front();
          if (out_data.compliance !== e.compliance)
            report("compliance", out_data.compliance, e.compliance);
          if (out_data.health_level !== e.health_level)
            report("health_level", out_data.health_level, e.health_level);
          if (out_data.authority !== e.authority)
            report("authority", out_data.authority, e.authority);
          if (out_data.overflow !== e.overflow)
            report("overflow", 16'(out_data.overflow), 16'(e.overflow));
        end
        words_seen++;
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL range_compliance_health_tracker");
      $finish;
    end
  end

  typedef struct {
    in_word_t w;
    bit check;
    out_word_t want;
  } row_t;

  initial begin
    row_t rows[$];
    row_t r;
    int n;
    rate_good = 16'd3277;
    rate_bad = 16'd16384;
    auth_thr = 16'd16384;
    auth_sharp = 16'd2560;
    health_q = 16'(ONE_Q15);
    run_sum = 0;
    run_count = 0;
    run_over = 1'b0;
    fill_logistic();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: in-range fields, zero range, inverted limits, extremes.
    rows.push_back('{mk(32'h0, 32'h10000, 32'h8000, 1), 1'b1,
                     '{16'd32768, 16'd32768, logistic[208], 1'b0}});
    rows.push_back('{mk(32'h5, 32'h5, 32'h5, 1), 1'b0, '0});
    rows.push_back('{mk(32'h5, 32'h5, 32'h6, 1), 1'b0, '0});
    rows.push_back('{mk(32'h10, 32'h0, 32'h8, 1), 1'b0, '0});
    rows.push_back('{mk(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1), 1'b0, '0});
    rows.push_back('{mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1), 1'b0, '0});
    rows.push_back('{mk(32'h0, 32'h100, 32'h180, 0), 1'b0, '0});
    rows.push_back('{mk(32'h0, 32'h100, 32'h200, 0), 1'b0, '0});
    rows.push_back('{mk(32'h0, 32'h100, 32'hffff_ff40, 1), 1'b0, '0});
    rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1), 1'b0, '0});
    rows.push_back('{mk(32'h0, 32'h1, 32'h8000_0000, 1), 1'b0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      if (r.check) begin
        send_field(r.w);
        void'(expected_words.pop_back());
        expected_words.push_back(r.want);
      end else begin
        send_field(r.w);
      end
    end
    // Overflow: one run longer than the field limit.
    for (int i = 0; i < NUM_FIELDS + 3; i++)
      send_field(mk(32'h0, 32'h100, 32'h80, i == NUM_FIELDS + 2));
    drain();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GOOD_RATE, 16'd0);
          write_reg(REG_BAD_RATE, 16'd32768);
        end
        1: begin
          write_reg(REG_GOOD_RATE, 16'hffff);
          write_reg(REG_BAD_RATE, 16'hffff);
          write_reg(REG_AUTH_THR, 16'hffff);
          write_reg(REG_AUTH_SHARP, 16'hffff);
        end
        2: begin
          write_reg(REG_AUTH_THR, 16'd0);
          write_reg(REG_AUTH_SHARP, 16'd0);
        end
        default: begin
          write_reg(REG_GOOD_RATE, 16'($urandom_range(0, 65535)));
          write_reg(REG_BAD_RATE, 16'($urandom_range(0, 40000)));
          write_reg(REG_AUTH_THR, 16'($urandom_range(0, 32768)));
          write_reg(REG_AUTH_SHARP, 16'($urandom));
        end
      endcase
      n = 0;
      while (n < RANDOM_ITEMS / 6) begin
        int len;
        len = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_field(rand_field(k == len - 1));
          n++;
        end
      end
      drain();
    end

    $display("fed %0d fields, checked %0d result words (%0d overflowed runs)",
             fields_sent, words_seen, overflow_runs);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS range_compliance_health_tracker");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, expected_words.size());
      $display("FAIL range_compliance_health_tracker");
    end
    $finish;
  end

endmodule
